@@ rtl/core/nndf_pkg.sv @@
// nndf_pkg: constants, types and helpers for the nearest neighbour distance filter
// no dependencies; used by every file under rtl/core except nndf_ram

package nndf_pkg;

	// store geometry and coordinate format
	localparam int REF_POINTS = 4096;
	localparam int COORD_BITS = 24;
	localparam int FIELD_W    = 24;
	localparam int COLOUR_W   = 8;
	localparam int OPCODE_W   = 2;
	localparam int DIST_W     = 52;
	localparam int DISC_W     = 32;
	localparam int REFCNT_W   = 13;

	localparam int ADDR_W   = (REF_POINTS > 1) ? $clog2(REF_POINTS) : 1;
	localparam int CNT_W    = $clog2(REF_POINTS + 1);
	localparam int POINT_W  = 3 * FIELD_W;
	localparam int ABS_W    = FIELD_W;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int SUM_W    = SQ_W + 2;

	// threshold register, reset to 0.1 in units of 2^-24
	localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(1677722);
	localparam int                CFG_DATA_W   = 64;
	localparam int                CFG_ADDR_W   = 4;
	localparam logic              REG_THRESH   = 1'b0;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic query;
		logic issue;
		logic finish;
	} nndf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic pipe_empty;
	} nndf_sts_t;

	// low COORD_BITS bits of a field taken as two's complement, sign extended
	function automatic logic [FIELD_W-1:0] coord_of(input logic [FIELD_W-1:0] raw);
		logic [FIELD_W-1:0] v;
		for (int i = 0; i < FIELD_W; i++) begin
			v[i] = (i < COORD_BITS) ? raw[i] : raw[COORD_BITS-1];
		end
		return v;
	endfunction

endpackage

@@ rtl/core/nndf_ram.sv @@
// nndf_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module nndf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/nndf_ctrl.sv @@
// nndf_ctrl: sequencing state machine and output valid flag
// depends on nndf_pkg

module nndf_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [nndf_pkg::OPCODE_W-1:0]       opcode,
	output logic                                in_stall,
	output logic                                out_valid,
	input  logic                                out_stall,
	output nndf_pkg::nndf_cmd_t                 cmd,
	input  nndf_pkg::nndf_sts_t                 sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (opcode)
				nndf_pkg::OP_CLEAR: cmd.clear = 1'b1;
				nndf_pkg::OP_LOAD:  cmd.load  = 1'b1;
				nndf_pkg::OP_QUERY: cmd.query = 1'b1;
				default:            cmd.clear = 1'b0;
			endcase
		end
		cmd.issue  = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_DRAIN) && sts.pipe_empty && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.query) begin
						state_q <= sts.count_zero ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/nndf_datapath.sv @@
// nndf_datapath: point store, distance pipeline, running minimum, counters, result register
// depends on nndf_pkg and nndf_ram

module nndf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nndf_pkg::nndf_cmd_t                 cmd,
	output nndf_pkg::nndf_sts_t                 sts,
	input  logic [nndf_pkg::DIST_W-1:0]         threshold,
	input  logic [nndf_pkg::FIELD_W-1:0]        pos_x,
	input  logic [nndf_pkg::FIELD_W-1:0]        pos_y,
	input  logic [nndf_pkg::FIELD_W-1:0]        pos_z,
	input  logic [nndf_pkg::COLOUR_W-1:0]       red,
	input  logic [nndf_pkg::COLOUR_W-1:0]       green,
	input  logic [nndf_pkg::COLOUR_W-1:0]       blue,
	output logic                                kept,
	output logic [nndf_pkg::FIELD_W-1:0]        out_x,
	output logic [nndf_pkg::FIELD_W-1:0]        out_y,
	output logic [nndf_pkg::FIELD_W-1:0]        out_z,
	output logic [nndf_pkg::COLOUR_W-1:0]       out_red,
	output logic [nndf_pkg::COLOUR_W-1:0]       out_green,
	output logic [nndf_pkg::COLOUR_W-1:0]       out_blue,
	output logic [nndf_pkg::DIST_W-1:0]         nearest_sq_distance,
	output logic [nndf_pkg::DISC_W-1:0]         discarded_total,
	output logic [nndf_pkg::REFCNT_W-1:0]       reference_count
);

	localparam int FW = nndf_pkg::FIELD_W;

	// control state
	logic [nndf_pkg::CNT_W-1:0]  count_q;
	logic [nndf_pkg::DISC_W-1:0] discard_q;
	logic [nndf_pkg::ADDR_W-1:0] addr_q;
	logic                        v_s1, v_s2, v_s3, v_s4;

	// query and pipeline payload
	logic [FW-1:0]                   qx_q, qy_q, qz_q;
	logic [nndf_pkg::COLOUR_W-1:0]   qr_q, qg_q, qb_q;
	logic [nndf_pkg::POINT_W-1:0]    ref_s1;
	logic [nndf_pkg::ABS_W-1:0]      ax_s2, ay_s2, az_s2;
	logic [nndf_pkg::SQ_W-1:0]       sx_s3, sy_s3, sz_s3;
	logic [nndf_pkg::SUM_W-1:0]      sum_s4;
	logic [nndf_pkg::DIST_W-1:0]     best_q;

	logic                            store_full;
	logic                            ram_we;
	logic [nndf_pkg::POINT_W-1:0]    wr_point;
	logic signed [FW:0]              dx, dy, dz;
	logic                            kept_next;
	logic [nndf_pkg::DISC_W-1:0]     discard_next;

	assign store_full = (count_q == nndf_pkg::CNT_W'(nndf_pkg::REF_POINTS));
	assign ram_we     = cmd.load && !store_full;
	assign wr_point   = {nndf_pkg::coord_of(pos_z), nndf_pkg::coord_of(pos_y),
		nndf_pkg::coord_of(pos_x)};

	nndf_ram #(
		.WIDTH(nndf_pkg::POINT_W),
		.DEPTH(nndf_pkg::REF_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(nndf_pkg::ADDR_W'(count_q)),
		.wdata(wr_point),
		.re   (cmd.issue),
		.raddr(addr_q),
		.rdata(ref_s1)
	);

	assign sts.count_zero = (count_q == '0);
	assign sts.scan_last  = (nndf_pkg::CNT_W'(addr_q) + nndf_pkg::CNT_W'(1)) == count_q;
	assign sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);

	// signed differences, one bit wider than a coordinate
	assign dx = $signed({qx_q[FW-1], qx_q}) - $signed({ref_s1[FW-1], ref_s1[FW-1:0]});
	assign dy = $signed({qy_q[FW-1], qy_q})
		- $signed({ref_s1[2*FW-1], ref_s1[2*FW-1:FW]});
	assign dz = $signed({qz_q[FW-1], qz_q})
		- $signed({ref_s1[3*FW-1], ref_s1[3*FW-1:2*FW]});

	assign kept_next    = !sts.count_zero && (best_q < threshold);
	assign discard_next = (!kept_next && (discard_q != '1)) ? discard_q + 1'b1 : discard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			discard_q <= '0;
			addr_q    <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q   <= '0;
				discard_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.finish) begin
				discard_q <= discard_next;
			end
			if (cmd.query) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload: query capture, distance stages, minimum, result register
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			qx_q   <= nndf_pkg::coord_of(pos_x);
			qy_q   <= nndf_pkg::coord_of(pos_y);
			qz_q   <= nndf_pkg::coord_of(pos_z);
			qr_q   <= red;
			qg_q   <= green;
			qb_q   <= blue;
			best_q <= '1;
		end else if (v_s4 && (nndf_pkg::DIST_W'(sum_s4) < best_q)) begin
			best_q <= nndf_pkg::DIST_W'(sum_s4);
		end
		ax_s2  <= nndf_pkg::ABS_W'(dx[FW] ? -dx : dx);
		ay_s2  <= nndf_pkg::ABS_W'(dy[FW] ? -dy : dy);
		az_s2  <= nndf_pkg::ABS_W'(dz[FW] ? -dz : dz);
		sx_s3  <= ax_s2 * ax_s2;
		sy_s3  <= ay_s2 * ay_s2;
		sz_s3  <= az_s2 * az_s2;
		sum_s4 <= nndf_pkg::SUM_W'(sx_s3) + nndf_pkg::SUM_W'(sy_s3)
			+ nndf_pkg::SUM_W'(sz_s3);
		if (cmd.finish) begin
			kept                <= kept_next;
			out_x               <= qx_q;
			out_y               <= qy_q;
			out_z               <= qz_q;
			out_red             <= qr_q;
			out_green           <= qg_q;
			out_blue            <= qb_q;
			nearest_sq_distance <= best_q;
			discarded_total     <= discard_next;
			reference_count     <= nndf_pkg::REFCNT_W'(count_q);
		end
	end

endmodule

@@ rtl/core/nearest_neighbor_distance_filter_unit.sv @@
// nearest_neighbor_distance_filter_unit: top level, threshold register and apb decode
// depends on nndf_pkg, nndf_ctrl, nndf_datapath and nndf_ram
//
// usage
//  - input channel (in_valid / in_stall) carries one opcode beat with xyz and colour:
//    clear empties the store and zeroes the discard count, load appends a reference
//    point (dropped once 4096 points are held), query searches the store
//  - clear and load give no result beat
//  - a query with n stored points makes one store read per cycle through the single
//    ram read port, then the distance pipeline (read, difference, square, sum) drains;
//    an empty store goes straight to the drain
//  - each query gives one output beat (out_valid / out_stall) from a result register;
//    a new beat may be accepted while the previous result still waits
//  - a stalled output only holds up the end of the next query, not its scan
//  - the threshold sits at byte address 0 of the apb port (64 bit data, low 52 used);
//    it is to be written only while the block is idle, which the block does not enforce
//  - reset empties the store count and discard count and restores the threshold
//    to 0.1; the ram has no reset or clearing pass, reads never pass the fill count

module nearest_neighbor_distance_filter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// apb configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [nndf_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [nndf_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [nndf_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready,
	// input beats
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [nndf_pkg::OPCODE_W-1:0]         opcode,
	input  logic [nndf_pkg::FIELD_W-1:0]          pos_x,
	input  logic [nndf_pkg::FIELD_W-1:0]          pos_y,
	input  logic [nndf_pkg::FIELD_W-1:0]          pos_z,
	input  logic [nndf_pkg::COLOUR_W-1:0]         red,
	input  logic [nndf_pkg::COLOUR_W-1:0]         green,
	input  logic [nndf_pkg::COLOUR_W-1:0]         blue,
	// result beats
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  kept,
	output logic [nndf_pkg::FIELD_W-1:0]          out_x,
	output logic [nndf_pkg::FIELD_W-1:0]          out_y,
	output logic [nndf_pkg::FIELD_W-1:0]          out_z,
	output logic [nndf_pkg::COLOUR_W-1:0]         out_red,
	output logic [nndf_pkg::COLOUR_W-1:0]         out_green,
	output logic [nndf_pkg::COLOUR_W-1:0]         out_blue,
	output logic [nndf_pkg::DIST_W-1:0]           nearest_sq_distance,
	output logic [nndf_pkg::DISC_W-1:0]           discarded_total,
	output logic [nndf_pkg::REFCNT_W-1:0]         reference_count
);

	logic [nndf_pkg::DIST_W-1:0] thresh_q;
	logic                        reg_sel;
	nndf_pkg::nndf_cmd_t         cmd;
	nndf_pkg::nndf_sts_t         sts;

	// register index from the 8-byte slot, byte lanes within a slot ignored
	assign reg_sel = paddr[nndf_pkg::CFG_ADDR_W-1];
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_sel)
			nndf_pkg::REG_THRESH: prdata = nndf_pkg::CFG_DATA_W'(thresh_q);
			default:              prdata = '0;
		endcase
	end

	// threshold write on the access phase; other slots are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= nndf_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite && pready && (reg_sel == nndf_pkg::REG_THRESH)) begin
			thresh_q <= pwdata[nndf_pkg::DIST_W-1:0];
		end
	end

	// sequencing: idle, scan of the store, drain and result hand-off
	nndf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// point store, distance pipeline and result register
	nndf_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.threshold          (thresh_q),
		.pos_x              (pos_x),
		.pos_y              (pos_y),
		.pos_z              (pos_z),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.kept               (kept),
		.out_x              (out_x),
		.out_y              (out_y),
		.out_z              (out_z),
		.out_red            (out_red),
		.out_green          (out_green),
		.out_blue           (out_blue),
		.nearest_sq_distance(nearest_sq_distance),
		.discarded_total    (discarded_total),
		.reference_count    (reference_count)
	);

endmodule
